// File: src/hhue_pkg.sv
// package: shared types, codes and constants of the hopfield unlearning engine
package hhue_pkg;

  localparam int NEURONS_DEF       = 32;
  localparam int COUPLING_BITS_DEF = 24;
  localparam int IDX_W             = 6;
  localparam int DELTA_W           = 18;
  localparam int CFG_W             = 20;
  localparam int CFG_IDX_W         = 2;
  localparam int SPIN_W            = 32;
  localparam int COUNT_W           = 20;
  localparam int Q8_ONE            = 256;
  localparam int STRENGTH_RESET    = 256;
  localparam int SETTLE_RESET      = 20;
  localparam int MAX_SWEEPS_RESET  = 1000000;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_STORE   = 2'd1,
    OP_UNLEARN = 2'd2,
    OP_RECALL  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRENGTH = 2'd0,
    CFG_SETTLE   = 2'd1,
    CFG_MAX      = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FEED,
    S_DRAIN,
    S_DECIDE,
    S_DONE
  } fsm_t;

  // word travelling down the row of cells
  typedef struct packed {
    logic             valid;
    logic             spin;
    logic             last;
    logic [IDX_W-1:0] idx;
  } link_t;

  // broadcast to all cells
  typedef struct packed {
    logic                      update;
    logic signed [DELTA_W-1:0] delta;
    logic                      clear;
    logic                      clip_clr;
  } cell_cmd_t;

endpackage

// File: src/hhue_if.sv
// interfaces: input item and result channels
interface hhue_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] spin_vector;
  modport source (output valid, operation, spin_vector, input ready);
  modport sink (input valid, operation, spin_vector, output ready);
endinterface

interface hhue_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] final_state;
  logic [19:0] sweep_count;
  logic        settled;
  logic        saturated;
  modport source (output valid, final_state, sweep_count, settled, saturated, input ready);
  modport sink (input valid, final_state, sweep_count, settled, saturated, output ready);
endinterface

// File: src/hopfield_hebbian_unlearning_engine_unit.sv
// top level: hopfield coupling store with hebbian learning, unlearning and recall
// req carries operation and spin_vector; rsp returns one result word per item.
// cfg_we/cfg_index/cfg_data write strength, settle count and sweep limit.
// couplings sit in a row of NEURONS cells, one row each; a spin stream walks
// down the row one cell per cycle, every cell rotating its ring in step.
// clear needs no pass of the row. store and unlearn: one pass of the row.
// recall: one pass per sweep;
// the loop ends at a fixed point, a two-state oscillation or the sweep limit, with the
// remaining sweeps counted arithmetically, so sweeps run is at most the transient length + 2.
// req.ready is high only while no item is in work; one item at a time.
// a finished result waits in the rsp register while rsp.ready is low; the
// next item can be taken meanwhile and finishes only once rsp is free.
// reset clears all couplings at once and loads register defaults.
module hopfield_hebbian_unlearning_engine_unit import hhue_pkg::*; #(
  parameter int NEURONS       = NEURONS_DEF,
  parameter int COUPLING_BITS = COUPLING_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  hhue_in_if.sink              req,
  hhue_out_if.source           rsp
);

  localparam int SW = (NEURONS > SPIN_W) ? NEURONS : SPIN_W;
  localparam int KW = $clog2(SW);

  logic [15:0]        strength;
  logic [7:0]         settle;
  logic [COUNT_W-1:0] max_sw;

  fsm_t               fsm, fsm_next;
  op_t                op;
  logic [IDX_W-1:0]   k;
  logic [SW-1:0]      cur, prev, nxt;
  logic               have_prev;
  logic [COUNT_W-1:0] t;
  logic               settled;
  logic               upd;
  logic signed [DELTA_W-1:0] delta;
  logic               clr_pulse;
  logic               accept;

  link_t              link [NEURONS+1];
  logic [NEURONS-1:0] done, fire, clip;
  cell_cmd_t          cmd;

  logic [COUNT_W-1:0] t1, b, rem;
  logic [7:0]         a;

  assign accept = req.valid && req.ready;
  assign req.ready = (fsm == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= 16'(STRENGTH_RESET);
      settle   <= 8'(SETTLE_RESET);
      max_sw   <= COUNT_W'(MAX_SWEEPS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STRENGTH: strength <= cfg_data[15:0];
        CFG_SETTLE:   settle   <= cfg_data[7:0];
        CFG_MAX:      max_sw   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd.update   = upd;
    cmd.delta    = delta;
    cmd.clear    = clr_pulse;
    cmd.clip_clr = accept;
    link[0].valid = (fsm == S_FEED);
    link[0].spin  = cur[k[KW-1:0]];
    link[0].last  = (k == IDX_W'(NEURONS - 1));
    link[0].idx   = k;
  end

  for (genvar i = 0; i < NEURONS; i++) begin : g_cell
    hhue_cell #(
      .NEURONS(NEURONS), .COUPLING_BITS(COUPLING_BITS), .INDEX(i)
    ) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .own_spin(cur[i]),
      .link_in(link[i]), .link_out(link[i+1]),
      .done(done[i]), .fire(fire[i]), .clip(clip[i])
    );
  end

  always_comb begin
    t1  = t + COUNT_W'(1);
    a   = settle - 8'd1;
    b   = max_sw - t1;
    rem = max_sw - t1;
  end

  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(req.operation))
            OP_CLEAR:  fsm_next = S_DONE;
            OP_RECALL: fsm_next = (settle == '0 || max_sw == '0) ? S_DONE : S_FEED;
            default:   fsm_next = S_FEED;
          endcase
        end
      end
      S_FEED:   if (link[0].last) fsm_next = S_DRAIN;
      S_DRAIN:  if (done[NEURONS-1]) fsm_next = S_DECIDE;
      S_DECIDE: begin
        if (op != OP_RECALL || nxt == cur || (have_prev && nxt == prev) || t1 >= max_sw)
          fsm_next = S_DONE;
        else
          fsm_next = S_FEED;
      end
      S_DONE:   if (!rsp.valid || rsp.ready) fsm_next = S_IDLE;
      default:  fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) fsm <= S_IDLE;
    else     fsm <= fsm_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_pulse <= 1'b0;
      upd       <= 1'b0;
    end else begin
      clr_pulse <= accept && op_t'(req.operation) == OP_CLEAR;
      if (accept) upd <= op_t'(req.operation) == OP_STORE
                      || op_t'(req.operation) == OP_UNLEARN;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NEURONS; i++) if (done[i]) nxt[i] <= fire[i];
    case (fsm)
      S_IDLE: begin
        if (accept) begin
          op        <= op_t'(req.operation);
          cur       <= SW'(req.spin_vector);
          t         <= '0;
          have_prev <= 1'b0;
          settled   <= (settle == '0);
          k         <= '0;
          delta     <= (op_t'(req.operation) == OP_STORE) ? DELTA_W'(Q8_ONE)
                                                          : -DELTA_W'(strength);
        end
      end
      S_FEED: begin
        k <= link[0].last ? '0 : k + IDX_W'(1);
        if (k == '0) nxt <= '0;
      end
      S_DECIDE: begin
        if (op == OP_RECALL) begin
          if (nxt == cur) begin
            if (settle <= 8'd1) begin
              t <= t1;
              settled <= 1'b1;
            end else if (COUNT_W'(a) <= b) begin
              t <= t1 + COUNT_W'(a);
              settled <= 1'b1;
            end else begin
              t <= t1 + b;
              settled <= 1'b0;
            end
          end else if (have_prev && nxt == prev) begin
            if (!rem[0]) cur <= nxt;
            t <= max_sw;
          end else begin
            prev      <= cur;
            cur       <= nxt;
            have_prev <= 1'b1;
            t         <= t1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fsm == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid       <= 1'b1;
      rsp.final_state <= (op == OP_RECALL) ? cur[SPIN_W-1:0] : '0;
      rsp.sweep_count <= (op == OP_RECALL) ? t : '0;
      rsp.settled     <= (op == OP_RECALL) && settled;
      rsp.saturated   <= (op == OP_STORE || op == OP_UNLEARN) && (|clip);
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second item taken while one is in work");

  a_sat_only_update: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.saturated |-> rsp.final_state == '0 && rsp.sweep_count == '0
      && !rsp.settled)
    else $error("saturation flag on a recall result");

  a_stream_quiet: assert property (@(posedge clk) disable iff (rst)
    fsm == S_IDLE |-> !link[0].valid)
    else $error("spin stream running while idle");

endmodule

// File: src/hhue_cell.sv
// cell: one coupling row as a rotating ring, field accumulator and outer-product update
module hhue_cell import hhue_pkg::*; #(
  parameter int NEURONS       = NEURONS_DEF,
  parameter int COUPLING_BITS = COUPLING_BITS_DEF,
  parameter int INDEX         = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      own_spin,
  input  link_t     link_in,
  output link_t     link_out,
  output logic      done,
  output logic      fire,
  output logic      clip
);

  localparam int ACC_W = COUPLING_BITS + $clog2(NEURONS) + 1;
  localparam int SUM_W = ((COUPLING_BITS > DELTA_W) ? COUPLING_BITS : DELTA_W) + 1;
  localparam logic signed [SUM_W-1:0] HI = SUM_W'((64'sd1 <<< (COUPLING_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] LO = -HI - SUM_W'(1);

  logic signed [COUPLING_BITS-1:0] ring [NEURONS];
  logic signed [COUPLING_BITS-1:0] head_next;
  logic signed [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]         acc_next;
  logic signed [ACC_W-1:0]         term;
  logic signed [SUM_W-1:0]         dsel;
  logic signed [SUM_W-1:0]         sum;
  logic                            clip_hit;

  always_comb begin
    term     = link_in.spin ? ACC_W'(ring[0]) : -ACC_W'(ring[0]);
    acc_next = ((link_in.idx == '0) ? '0 : acc) + term;
    dsel     = (own_spin == link_in.spin) ? SUM_W'(cmd.delta) : -SUM_W'(cmd.delta);
    sum      = SUM_W'(ring[0]) + dsel;
    clip_hit = 1'b0;
    head_next = ring[0];
    if (cmd.update && link_in.idx != IDX_W'(INDEX)) begin
      if (sum > HI) begin
        head_next = COUPLING_BITS'(HI);
        clip_hit  = 1'b1;
      end else if (sum < LO) begin
        head_next = COUPLING_BITS'(LO);
        clip_hit  = 1'b1;
      end else begin
        head_next = COUPLING_BITS'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int n = 0; n < NEURONS; n++) ring[n] <= '0;
    end else if (link_in.valid) begin
      for (int n = 0; n < NEURONS - 1; n++) ring[n] <= ring[n+1];
      ring[NEURONS-1] <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.valid) acc <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
      done     <= 1'b0;
      clip     <= 1'b0;
    end else begin
      link_out <= link_in;
      done     <= link_in.valid && link_in.last;
      if (cmd.clip_clr) clip <= 1'b0;
      else if (link_in.valid && clip_hit) clip <= 1'b1;
    end
  end

  // field strictly positive
  assign fire = !acc[ACC_W-1] && (acc != '0);

endmodule

// File: tb/tb_top.sv
// testbench: drives coupling operations and recalls, predicts and checks every result word
module tb_top import hhue_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = 32;
  localparam int CB = 24;
  localparam longint LIMIT = 3000000;

  typedef struct {
    op_t         op;
    logic [31:0] spins;
  } job_t;

  typedef struct {
    logic [31:0] state;
    logic [19:0] sweeps;
    logic        settled;
    logic        clipped;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  hhue_in_if req ();
  hhue_out_if rsp ();

  hopfield_hebbian_unlearning_engine_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  job_t job_q[$];
  outcome_t outcome_q[$];
  logic [31:0] pattern_q[$];
  longint couplings[N][N];
  int unsigned strength, settle_lim, sweep_lim;
  int errors = 0;
  longint cycles = 0;
  int taken = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit no_idle = 0;
  logic hold_rx = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic bit add_outer(logic [31:0] v, longint delta);
    longint hi, lo, x;
    bit clip;
    hi = (longint'(1) <<< (CB - 1)) - 1;
    lo = -hi - 1;
    clip = 0;
    for (int i = 0; i < N; i++) begin
      for (int j = i + 1; j < N; j++) begin
        x = couplings[i][j] + ((v[i] == v[j]) ? delta : -delta);
        if (x > hi) begin
          x = hi;
          clip = 1;
        end
        if (x < lo) begin
          x = lo;
          clip = 1;
        end
        couplings[i][j] = x;
        couplings[j][i] = x;
      end
    end
    return clip;
  endfunction

  function automatic logic [31:0] one_sweep(logic [31:0] v);
    logic [31:0] r;
    longint field;
    r = '0;
    for (int i = 0; i < N; i++) begin
      field = 0;
      for (int j = 0; j < N; j++) field += v[j] ? couplings[i][j] : -couplings[i][j];
      r[i] = (field > 0);
    end
    return r;
  endfunction

  function automatic outcome_t predict_outcome(job_t jb);
    outcome_t o;
    int unsigned t, flag, a, b, rem;
    logic [31:0] cur, prev, nxt;
    bit have_prev;
    o = '{default: '0};
    case (jb.op)
      OP_CLEAR: begin
        foreach (couplings[i, j]) couplings[i][j] = 0;
      end
      OP_STORE: o.clipped = add_outer(jb.spins, Q8_ONE);
      OP_UNLEARN: o.clipped = add_outer(jb.spins, -longint'(strength));
      default: begin
        t = 0;
        flag = 0;
        cur = jb.spins;
        prev = '0;
        have_prev = 0;
        while (flag < settle_lim && t < sweep_lim) begin
          nxt = one_sweep(cur);
          t++;
          if (nxt == cur) begin
            flag++;
            a = (flag < settle_lim) ? settle_lim - flag : 0;
            b = sweep_lim - t;
            flag += (a < b) ? a : b;
            t += (a < b) ? a : b;
            break;
          end
          if (have_prev && nxt == prev) begin
            rem = sweep_lim - t;
            cur = rem[0] ? cur : nxt;
            t = sweep_lim;
            break;
          end
          prev = cur;
          cur = nxt;
          have_prev = 1;
        end
        o.state = cur;
        o.sweeps = t[19:0];
        o.settled = (flag >= settle_lim);
      end
    endcase
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    job_t jb;
    bit acc;
    if (rst) begin
      req.valid <= 1'b0;
      req.operation <= '0;
      req.spin_vector <= '0;
    end else begin
      acc = req.valid && req.ready;
      if (acc) begin
        jb.op = op_t'(req.operation);
        jb.spins = req.spin_vector;
        outcome_q.push_back(predict_outcome(jb));
        taken++;
        send_gap = draw_gap();
      end
      if (!req.valid || acc) begin
        if (send_gap > 0) begin
          send_gap--;
          req.valid <= 1'b0;
        end else if (job_q.size() > 0) begin
          jb = job_q.pop_front();
          req.valid <= 1'b1;
          req.operation <= jb.op;
          req.spin_vector <= jb.spins;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word: state %h", rsp.final_state);
        end else begin
          e = outcome_q.pop_front();
          if (rsp.final_state !== e.state || rsp.sweep_count !== e.sweeps ||
              rsp.settled !== e.settled || rsp.saturated !== e.clipped) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b", e.state, e.sweeps,
                       e.settled, e.clipped, rsp.final_state, rsp.sweep_count,
                       rsp.settled, rsp.saturated);
          end
        end
        recv_gap = draw_gap();
      end
      if (hold_rx) begin
        rsp.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // long receiver hold while the sender keeps offering
  initial begin
    @(negedge clk);
    while (taken < 40) @(negedge clk);
    @(posedge clk) hold_rx <= 1'b1;
    repeat (800) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add(op_t o, logic [31:0] s);
    job_q.push_back('{op: o, spins: s});
    if (o == OP_STORE) pattern_q.push_back(s);
    if (o == OP_CLEAR) pattern_q.delete();
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (job_q.size() != 0 || outcome_q.size() != 0 || req.valid || hold_rx);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STRENGTH: strength = val & 32'hFFFF;
      CFG_SETTLE: settle_lim = val & 32'hFF;
      CFG_MAX: sweep_lim = val & 32'hFFFFF;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] near_pattern();
    logic [31:0] p;
    if (pattern_q.size() == 0) return $urandom();
    p = pattern_q[$urandom_range(0, pattern_q.size() - 1)];
    if ($urandom_range(0, 1)) p = ~p;
    repeat ($urandom_range(0, 6)) p[$urandom_range(0, 31)] ^= 1'b1;
    return p;
  endfunction

  task automatic random_items(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) add(OP_CLEAR, $urandom());
      else if (r < 38) add(OP_STORE, $urandom_range(0, 3) == 0 ? $urandom() : near_pattern());
      else if (r < 58) add(OP_UNLEARN, $urandom_range(0, 1) ? $urandom() : near_pattern());
      else add(OP_RECALL, $urandom_range(0, 3) == 0 ? $urandom() : near_pattern());
    end
  endtask

  initial begin
    int unsigned maxes[5];
    foreach (couplings[i, j]) couplings[i][j] = 0;
    strength = STRENGTH_RESET;
    settle_lim = SETTLE_RESET;
    sweep_lim = MAX_SWEEPS_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // default registers
    add(OP_RECALL, 32'h0);
    add(OP_CLEAR, 32'hFFFFFFFF);
    add(OP_STORE, 32'hFFFFFFFF);
    add(OP_STORE, 32'h00000000);
    add(OP_STORE, 32'hAAAAAAAA);
    add(OP_STORE, 32'h5555AAAA);
    add(OP_RECALL, 32'hAAAA0000);
    add(OP_RECALL, 32'hFFFFFFFF);
    add(OP_UNLEARN, 32'h0F0F0F0F);
    add(OP_RECALL, 32'h00000001);
    add(OP_RECALL, 32'h80000000);
    wait_idle();
    // no settling sweeps asked
    write_reg(CFG_SETTLE, 0);
    add(OP_RECALL, 32'h12345678);
    wait_idle();
    write_reg(CFG_MAX, 0);
    add(OP_RECALL, 32'hDEADBEEF);
    wait_idle();
    write_reg(CFG_SETTLE, 1);
    add(OP_RECALL, 32'hCAFEF00D);
    wait_idle();
    write_reg(CFG_SETTLE, 255);
    write_reg(CFG_MAX, 1);
    add(OP_RECALL, 32'h0000FFFF);
    add(OP_RECALL, 32'hFFFF0000);
    wait_idle();
    write_reg(CFG_STRENGTH, 0);
    write_reg(CFG_MAX, 1048575);
    add(OP_UNLEARN, 32'h33333333);
    add(OP_RECALL, 32'h33333333);
    wait_idle();

    // saturate in both directions
    write_reg(CFG_STRENGTH, 65535);
    add(OP_CLEAR, 32'h0);
    for (int k = 0; k < 140; k++) add(OP_UNLEARN, k < 130 ? 32'h12345678 : $urandom());
    add(OP_RECALL, 32'h12345678);
    add(OP_RECALL, $urandom());
    wait_idle();

    maxes = '{1, 2, 40, 1000000, 1048575};
    for (int ph = 0; ph < 6; ph++) begin
      no_idle = (ph == 2);
      write_reg(CFG_STRENGTH, ph == 0 ? 1 : $urandom_range(0, 1) ? $urandom_range(0, 512)
                : $urandom_range(0, 65535));
      write_reg(CFG_SETTLE, ph == 1 ? 255 : ph == 3 ? 1 : $urandom_range(1, 30));
      write_reg(CFG_MAX, maxes[$urandom_range(0, 4)]);
      if (ph % 2) add(OP_CLEAR, $urandom());
      random_items(70);
      wait_idle();
    end
    no_idle = 0;

    repeat (200) @(negedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
src/hhue_pkg.sv
src/hhue_if.sv
src/hhue_cell.sv
src/hopfield_hebbian_unlearning_engine_unit.sv
tb/tb_top.sv
